/* rtl/aswr_pkg.sv */
// types and codes shared by the acked sender blocks
package aswr_pkg;

    localparam int unsigned WaitW = 17;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_ACK  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_TX   = 2'd0,
        K_OK   = 2'd1,
        K_FAIL = 2'd2,
        K_BUSY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [15:0]        dest;
        logic signed [31:0] content;
        logic [7:0]         mtype;
        logic [7:0]         tries;
        logic [31:0]        ack_id;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        dest;
        logic [7:0]         mtype;
        logic signed [31:0] content;
        logic [31:0]        id;
    } t_result;

    typedef struct packed {
        logic fire;
    } t_flow;

endpackage

/* rtl/aswr_in_reg.sv */
// input register stage holding one accepted item
module aswr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  aswr_pkg::t_item i_item,
    input  logic           i_adv,
    output logic           o_stall,
    output logic           o_fire,
    output aswr_pkg::t_item o_item
);

    logic            r_valid;
    aswr_pkg::t_item r_item;
    logic            load;

    assign o_stall = r_valid && !i_adv;
    assign o_fire  = r_valid && i_adv;
    assign load    = !r_valid || i_adv;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/aswr_core.sv */
// sender state, timeout and retry logic
module aswr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  aswr_pkg::t_flow   i_flow,
    input  aswr_pkg::t_item   i_item,
    output logic              o_res_valid,
    output aswr_pkg::t_result o_res
);

    logic [15:0]                   r_timeout;
    logic [31:0]                   r_ms;
    aswr_pkg::t_state              r_state;
    logic [7:0]                    r_tries;
    logic [aswr_pkg::WaitW-1:0]    r_wait;
    logic [15:0]                   r_dest;
    logic [7:0]                    r_mtype;
    logic signed [31:0]            r_content;
    logic [31:0]                   r_id;

    logic [31:0]                   n_ms;
    aswr_pkg::t_state              n_state;
    logic [7:0]                    n_tries;
    logic [aswr_pkg::WaitW-1:0]    n_wait;
    logic                          n_load;
    logic [aswr_pkg::WaitW-1:0]    wait_inc;
    logic                          busy;

    assign busy = (r_state == aswr_pkg::ST_BUSY);

    always_comb begin
        n_ms        = r_ms;
        n_state     = r_state;
        n_tries     = r_tries;
        n_wait      = r_wait;
        n_load      = 1'b0;
        o_res_valid = 1'b0;
        o_res.kind    = aswr_pkg::K_TX;
        o_res.dest    = r_dest;
        o_res.mtype   = r_mtype;
        o_res.content = r_content;
        o_res.id      = r_id;
        wait_inc    = (r_wait == {aswr_pkg::WaitW{1'b1}}) ? r_wait
                    : r_wait + {{(aswr_pkg::WaitW-1){1'b0}}, 1'b1};
        if (i_flow.fire) begin
            unique case (i_item.op)
                aswr_pkg::OP_TICK: begin
                    n_ms = r_ms + 32'd1;
                    if (busy) begin
                        n_wait = wait_inc;
                        if (wait_inc > {1'b0, r_timeout}) begin
                            o_res_valid = 1'b1;
                            if (r_tries != 8'd0) begin
                                n_tries = r_tries - 8'd1;
                                n_wait  = '0;
                            end else begin
                                n_state    = aswr_pkg::ST_IDLE;
                                o_res.kind = aswr_pkg::K_FAIL;
                            end
                        end
                    end
                end
                aswr_pkg::OP_SEND: begin
                    o_res_valid = 1'b1;
                    if (busy) begin
                        o_res.kind    = aswr_pkg::K_BUSY;
                        o_res.dest    = '0;
                        o_res.mtype   = '0;
                        o_res.content = '0;
                        o_res.id      = '0;
                    end else begin
                        n_load        = 1'b1;
                        n_wait        = '0;
                        o_res.dest    = i_item.dest;
                        o_res.mtype   = i_item.mtype;
                        o_res.content = i_item.content;
                        o_res.id      = r_ms;
                        if (i_item.tries == 8'd0) begin
                            n_tries    = 8'd0;
                            o_res.kind = aswr_pkg::K_FAIL;
                        end else begin
                            n_tries = i_item.tries - 8'd1;
                            n_state = aswr_pkg::ST_BUSY;
                        end
                    end
                end
                aswr_pkg::OP_ACK: begin
                    if (busy && (i_item.ack_id == r_id)) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = aswr_pkg::K_OK;
                        n_state     = aswr_pkg::ST_IDLE;
                        n_tries     = 8'd0;
                    end
                end
                aswr_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd100;
            r_ms      <= '0;
            r_state   <= aswr_pkg::ST_IDLE;
            r_tries   <= '0;
            r_wait    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            r_ms    <= n_ms;
            r_state <= n_state;
            r_tries <= n_tries;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_dest    <= i_item.dest;
            r_mtype   <= i_item.mtype;
            r_content <= i_item.content;
            r_id      <= r_ms;
        end
    end

    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flow.fire && i_item.op == aswr_pkg::OP_SEND && !busy && i_item.tries != 8'd0
        |=> r_state == aswr_pkg::ST_BUSY)
        else $error("send with tries did not enter busy");

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flow.fire && i_item.op == aswr_pkg::OP_TICK
        |=> r_ms == $past(r_ms) + 32'd1)
        else $error("millisecond count did not advance on tick");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_flow.fire |=> r_state == $past(r_state) && r_ms == $past(r_ms))
        else $error("state moved without an item");

    a_send_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flow.fire && i_item.op == aswr_pkg::OP_SEND |-> o_res_valid)
        else $error("send request gave no result");

endmodule

/* rtl/aswr_out_reg.sv */
// output register holding one result item
module aswr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_res_valid,
    input  aswr_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_adv,
    output logic              o_valid,
    output aswr_pkg::t_result o_res
);

    logic              r_valid;
    aswr_pkg::t_result r_res;

    assign o_adv   = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_fire && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/acked_sender_with_retries.sv */
// top level of the stop-and-wait sender with ack timeout and retries
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     opcode, dest, content, type, tries, ack id
//  output    out        o_out_valid / i_out_stall   kind, frame dest, type, content, id
//  config    in         i_cfg_we                    ack timeout in ms
//
// one item per cycle while the output is not stalled; the result passes through the input register,
// then the state update into the output register
// synchronous active-low reset: idle, ms count and wait timer zero, timeout 100
// an output stall holds the result and stalls the input once the input register is full
module acked_sender_with_retries (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_dest_node,
    input  logic signed [31:0] i_msg_content,
    input  logic [7:0]         i_msg_type,
    input  logic [7:0]         i_send_tries,
    input  logic [31:0]        i_ack_id,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_frame_dest,
    output logic [7:0]         o_frame_type,
    output logic signed [31:0] o_frame_content,
    output logic [31:0]        o_frame_id
);

    aswr_pkg::t_item   in_item;
    aswr_pkg::t_item   s1_item;
    aswr_pkg::t_flow   flow;
    aswr_pkg::t_result core_res;
    aswr_pkg::t_result out_res;
    logic              core_res_valid;
    logic              fire;
    logic              adv;

    assign in_item.op      = aswr_pkg::t_op'(i_opcode);
    assign in_item.dest    = i_dest_node;
    assign in_item.content = i_msg_content;
    assign in_item.mtype   = i_msg_type;
    assign in_item.tries   = i_send_tries;
    assign in_item.ack_id  = i_ack_id;

    assign flow.fire = fire;

    aswr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_stall (o_in_stall),
        .o_fire  (fire),
        .o_item  (s1_item)
    );

    aswr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_flow      (flow),
        .i_item      (s1_item),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    aswr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (core_res_valid),
        .i_res       (core_res),
        .i_stall     (i_out_stall),
        .o_adv       (adv),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_frame_dest    = out_res.dest;
    assign o_frame_type    = out_res.mtype;
    assign o_frame_content = out_res.content;
    assign o_frame_id      = out_res.id;

endmodule

/* dv/acked_sender_with_retries_test.sv */
// self-checking testbench for the stop-and-wait sender with ack timeout and retries
module acked_sender_with_retries_test;

    localparam int CycleLimit = 1_000_000;

    typedef struct packed {
        aswr_pkg::t_item   it;
        logic              typed;
        logic              yields;
        aswr_pkg::t_result want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [15:0]        i_dest_node;
    logic signed [31:0] i_msg_content;
    logic [7:0]         i_msg_type;
    logic [7:0]         i_send_tries;
    logic [31:0]        i_ack_id;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_kind;
    logic [15:0]        o_frame_dest;
    logic [7:0]         o_frame_type;
    logic signed [31:0] o_frame_content;
    logic [31:0]        o_frame_id;

    acked_sender_with_retries DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_dest_node     (i_dest_node),
        .i_msg_content   (i_msg_content),
        .i_msg_type      (i_msg_type),
        .i_send_tries    (i_send_tries),
        .i_ack_id        (i_ack_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_frame_dest    (o_frame_dest),
        .o_frame_type    (o_frame_type),
        .o_frame_content (o_frame_content),
        .o_frame_id      (o_frame_id)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sender state as the block should hold it
    logic [15:0]       ack_timeout  = 16'd100;
    logic [31:0]       ms_now       = '0;
    logic [31:0]       waited       = '0;
    logic              in_flight    = 1'b0;
    logic [7:0]        retries_left = '0;
    aswr_pkg::t_result held         = '0;

    aswr_pkg::t_result frames_due[$];
    t_row              dir_rows[$];
    aswr_pkg::t_result want;
    int      errors       = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    int      kind_count[4] = '{0, 0, 0, 0};
    int      hold_left    = 0;
    int      cycles       = 0;
    bit      calm         = 1'b0;

    function automatic aswr_pkg::t_result frame(aswr_pkg::t_kind k, logic [15:0] d,
                                                logic [7:0] t, logic signed [31:0] c,
                                                logic [31:0] id);
        aswr_pkg::t_result r;
        r.kind    = k;
        r.dest    = d;
        r.mtype   = t;
        r.content = c;
        r.id      = id;
        return r;
    endfunction

    function automatic aswr_pkg::t_item itm(aswr_pkg::t_op op, logic [15:0] d,
                                            logic signed [31:0] c, logic [7:0] t,
                                            logic [7:0] n, logic [31:0] a);
        aswr_pkg::t_item it;
        it.op      = op;
        it.dest    = d;
        it.content = c;
        it.mtype   = t;
        it.tries   = n;
        it.ack_id  = a;
        return it;
    endfunction

    // advances the sender state by one item and gives the result it causes
    function automatic bit next_frame(input aswr_pkg::t_item it,
                                      output aswr_pkg::t_result r);
        r = '0;
        case (it.op)
            aswr_pkg::OP_TICK: begin
                ms_now = ms_now + 32'd1;
                if (!in_flight) return 1'b0;
                if (waited != '1) waited = waited + 32'd1;
                if (waited <= {16'd0, ack_timeout}) return 1'b0;
                r = held;
                if (retries_left != 0) begin
                    retries_left = retries_left - 8'd1;
                    waited = '0;
                    r.kind = aswr_pkg::K_TX;
                    return 1'b1;
                end
                in_flight = 1'b0;
                r.kind = aswr_pkg::K_FAIL;
                return 1'b1;
            end
            aswr_pkg::OP_SEND: begin
                if (in_flight) begin
                    r = frame(aswr_pkg::K_BUSY, '0, '0, '0, '0);
                    return 1'b1;
                end
                held = frame(aswr_pkg::K_TX, it.dest, it.mtype, it.content, ms_now);
                waited = '0;
                r = held;
                if (it.tries == 0) begin
                    retries_left = '0;
                    r.kind = aswr_pkg::K_FAIL;
                    return 1'b1;
                end
                retries_left = it.tries - 8'd1;
                in_flight = 1'b1;
                return 1'b1;
            end
            aswr_pkg::OP_ACK: begin
                if (in_flight && it.ack_id == held.id) begin
                    in_flight = 1'b0;
                    retries_left = '0;
                    r = held;
                    r.kind = aswr_pkg::K_OK;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // mostly well-formed exchanges, with noise and stray acks mixed in
    function automatic aswr_pkg::t_item pick_event();
        aswr_pkg::t_item it;
        int roll;
        int n;
        it = itm(aswr_pkg::OP_TICK, 16'($urandom), $urandom, 8'($urandom), 8'($urandom),
                 $urandom);
        roll = $urandom_range(0, 99);
        n = $urandom_range(0, 99);
        if (!in_flight) begin
            if (roll < 45) begin
                it.op = aswr_pkg::OP_SEND;
                if (n < 8) it.tries = '0;
                else if (n < 80) it.tries = 8'($urandom_range(1, 4));
            end else if (roll < 80) begin
                it.op = aswr_pkg::OP_TICK;
            end else if (roll < 92) begin
                it.op = aswr_pkg::OP_ACK;
                if (n < 50) it.ack_id = held.id;
            end else begin
                it.op = aswr_pkg::OP_NONE;
            end
        end else begin
            if (roll < 58) begin
                it.op = aswr_pkg::OP_TICK;
            end else if (roll < 78) begin
                it.op = aswr_pkg::OP_ACK;
                it.ack_id = held.id;
            end else if (roll < 86) begin
                it.op = aswr_pkg::OP_ACK;
                if (n < 50) it.ack_id = held.id ^ (32'd1 << $urandom_range(0, 31));
            end else if (roll < 94) begin
                it.op = aswr_pkg::OP_SEND;
            end else begin
                it.op = aswr_pkg::OP_NONE;
            end
        end
        return it;
    endfunction

    function automatic void add_row(aswr_pkg::t_item it, bit typed, bit yields,
                                    aswr_pkg::t_result w);
        t_row r;
        r.it     = it;
        r.typed  = typed;
        r.yields = yields;
        r.want   = w;
        dir_rows.push_back(r);
    endfunction

    // presents one item and returns at the edge that accepts it
    task automatic put_item(input aswr_pkg::t_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= it.op;
        i_dest_node   <= it.dest;
        i_msg_content <= it.content;
        i_msg_type    <= it.mtype;
        i_send_tries  <= it.tries;
        i_ack_id      <= it.ack_id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic deliver(input aswr_pkg::t_item it, input bit typed = 1'b0,
                           input bit yields = 1'b0, input aswr_pkg::t_result w = '0);
        aswr_pkg::t_result r;
        bit                got;
        put_item(it);
        items_sent++;
        got = next_frame(it, r);
        if (typed) begin
            if (yields) frames_due.push_back(w);
        end else if (got) begin
            frames_due.push_back(r);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ack_timeout = v;
    endtask

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            deliver(pick_event());
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (frames_due.size() == 0) begin
                $error("unexpected result: kind %0d id %0h", o_kind, o_frame_id);
                errors++;
            end else begin
                want = frames_due.pop_front();
                kind_count[want.kind]++;
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errors++;
                end
                if (o_frame_dest !== want.dest) begin
                    $error("frame_dest: expected %0h, got %0h", want.dest, o_frame_dest);
                    errors++;
                end
                if (o_frame_type !== want.mtype) begin
                    $error("frame_type: expected %0h, got %0h", want.mtype, o_frame_type);
                    errors++;
                end
                if (o_frame_content !== want.content) begin
                    $error("frame_content: expected %0d, got %0d", want.content,
                           o_frame_content);
                    errors++;
                end
                if (o_frame_id !== want.id) begin
                    $error("frame_id: expected %0h, got %0h", want.id, o_frame_id);
                    errors++;
                end
            end
            hold_left = calm ? 0 : $urandom_range(0, 7);
            i_out_stall <= (hold_left != 0);
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= (hold_left != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("acked_sender_with_retries_test NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_opcode      = aswr_pkg::OP_NONE;
        i_dest_node   = '0;
        i_msg_content = '0;
        i_msg_type    = '0;
        i_send_tries  = '0;
        i_ack_id      = '0;
        i_out_stall   = 1'b0;

        // reset timeout of 100, count starts at zero
        add_row(itm(aswr_pkg::OP_TICK, '0, '0, '0, '0, '0), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, '0), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_SEND, 16'hFFFF, 32'sh8000_0000, 8'hFF, 8'd0, '0), 1, 1,
                frame(aswr_pkg::K_FAIL, 16'hFFFF, 8'hFF, 32'sh8000_0000, 32'd1));
        add_row(itm(aswr_pkg::OP_NONE, 16'hFFFF, -1, 8'hFF, 8'hFF, 32'hFFFF_FFFF), 1, 0,
                '0);
        add_row(itm(aswr_pkg::OP_SEND, 16'h0000, 32'sh7FFF_FFFF, 8'h00, 8'd1, '0), 1, 1,
                frame(aswr_pkg::K_TX, 16'h0000, 8'h00, 32'sh7FFF_FFFF, 32'd1));
        add_row(itm(aswr_pkg::OP_SEND, 16'hFFFF, -1, 8'hFF, 8'hFF, '0), 1, 1,
                frame(aswr_pkg::K_BUSY, '0, '0, '0, '0));
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd0), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd1), 1, 1,
                frame(aswr_pkg::K_OK, 16'h0000, 8'h00, 32'sh7FFF_FFFF, 32'd1));
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd1), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_TICK, '0, '0, '0, '0, '0), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_SEND, 16'h1234, -5, 8'h5A, 8'hFF, '0), 1, 1,
                frame(aswr_pkg::K_TX, 16'h1234, 8'h5A, -5, 32'd2));
        add_row(itm(aswr_pkg::OP_TICK, '0, '0, '0, '0, '0), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'hFFFF_FFFF), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd3), 1, 0, '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd2), 1, 1,
                frame(aswr_pkg::K_OK, 16'h1234, 8'h5A, -5, 32'd2));
        add_row(itm(aswr_pkg::OP_SEND, 16'hA5A5, 32'sh5555_5555, 8'hA5, 8'd2, '0), 0, 0,
                '0);
        add_row(itm(aswr_pkg::OP_TICK, 16'h5A5A, 32'shAAAA_AAAA, 8'h5A, 8'hFD,
                    32'h5555_5555), 0, 0, '0);
        add_row(itm(aswr_pkg::OP_SEND, 16'h5A5A, 32'shAAAA_AAAA, 8'h5A, 8'd0, '0), 0, 0,
                '0);
        add_row(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, 32'd3), 0, 0, '0);
        add_row(itm(aswr_pkg::OP_NONE, '0, '0, '0, '0, '0), 1, 0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            deliver(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].want);

        set_timeout(16'd0);
        run_random(220);
        set_timeout(16'd1);
        run_random(220);
        set_timeout(16'($urandom_range(2, 12)));
        run_random(220);
        set_timeout(16'd100);
        run_random(220);
        set_timeout(16'($urandom_range(0, 40)));
        run_random(220);

        // longest timeout: no resend within a few hundred ticks, then acked
        set_timeout(16'hFFFF);
        calm = 1'b1;
        deliver(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, held.id));
        deliver(itm(aswr_pkg::OP_SEND, 16'($urandom), $urandom, 8'($urandom), 8'd2,
                    $urandom));
        for (int k = 0; k < 200; k++)
            deliver(itm(aswr_pkg::OP_TICK, 16'($urandom), $urandom, 8'($urandom),
                        8'($urandom), $urandom));
        deliver(itm(aswr_pkg::OP_ACK, '0, '0, '0, '0, held.id));
        calm = 1'b0;
        settle();

        $display("%0d items in, %0d results checked: %0d frames, %0d acked,",
                 items_sent, results_seen, kind_count[aswr_pkg::K_TX],
                 kind_count[aswr_pkg::K_OK]);
        $display("%0d failed, %0d busy; ack timeouts run: reset value, 0, 1, small values, 65535",
                 kind_count[aswr_pkg::K_FAIL], kind_count[aswr_pkg::K_BUSY]);
        if (errors == 0) begin
            $display("acked_sender_with_retries_test OK");
        end else begin
            $display("acked_sender_with_retries_test NOT OK");
        end
        $finish;
    end

endmodule
